>>> rtl/core/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg: shared types and constants of the CSV byte tokenizer
// Parse state codes, status codes, register indexes and the structs passed
// between the parse step and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

	// parse state codes
	localparam logic [2:0] PS_SOST = 3'd0;  // start of start of term
	localparam logic [2:0] PS_SOT  = 3'd1;  // start of term
	localparam logic [2:0] PS_CR   = 3'd2;  // after CR
	localparam logic [2:0] PS_UNQ  = 3'd3;  // in unquoted term
	localparam logic [2:0] PS_QUO  = 3'd4;  // in quoted term
	localparam logic [2:0] PS_ENDQ = 3'd5;  // after closing quote

	// result status codes
	localparam logic [1:0] RC_OK   = 2'd0;
	localparam logic [1:0] RC_TERM = 2'd1;
	localparam logic [1:0] RC_ROW  = 2'd2;
	localparam logic [1:0] RC_ERR  = 2'd3;

	// configuration register indexes
	localparam logic REG_SEPARATOR = 1'b0;
	localparam logic REG_LIMIT     = 1'b1;

	localparam logic [7:0] SEPARATOR_RST = 8'd44;
	localparam logic [7:0] LIMIT_RST     = 8'd64;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	typedef struct packed {
		logic [2:0] parse_state;
		logic [7:0] term_count;
	} parse_t;

	typedef struct packed {
		logic [1:0] status;
		logic       byte_stored;
		logic [7:0] stored_index;
		logic [7:0] term_length;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/csvt_step.sv
// ----------------------------------------------------------------------------
// csvt_step: parse step for one byte
// Computes the next parse state, the term count and the result of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_step
	import csvt_pkg::*;
(
	input  wire logic [7:0] in_byte,
	input  wire logic [7:0] separator,
	input  wire logic [7:0] limit,
	input  wire parse_t     cur,
	output parse_t          nxt,
	output result_t         res
);

	logic [2:0] st;
	logic [7:0] cnt;
	logic [1:0] rc;
	logic       stored;
	logic [7:0] idx;
	logic       begin_term;
	logic       open_term;
	logic       unq;
	logic       end_check;
	logic       end_hit;
	logic       append;

	always_comb begin
		st         = cur.parse_state;
		cnt        = cur.term_count;
		rc         = RC_OK;
		stored     = 1'b0;
		idx        = 8'd0;
		begin_term = 1'b0;
		open_term  = 1'b0;
		unq        = 1'b0;
		end_check  = 1'b0;
		end_hit    = 1'b0;
		append     = 1'b0;

		if (limit == 8'd0) begin
			rc = RC_ERR;
		end else begin
			case (cur.parse_state)
				PS_SOST: begin
					begin_term = 1'b1;
				end
				PS_CR: begin
					if (in_byte == CH_LF) begin
						st = PS_SOST;
					end else begin
						begin_term = 1'b1;
					end
				end
				PS_SOT: begin
					open_term = 1'b1;
				end
				PS_UNQ: begin
					unq = 1'b1;
				end
				PS_QUO, PS_ENDQ: begin
					if (in_byte == CH_QUOTE) begin
						st = PS_ENDQ;
					end else if (cur.parse_state == PS_ENDQ) begin
						end_check = 1'b1;
					end else begin
						append = 1'b1;
					end
				end
				default: begin
					rc = RC_ERR;
				end
			endcase

			// a new term clears the count before the byte is looked at
			if (begin_term) begin
				cnt       = 8'd0;
				open_term = 1'b1;
			end
			if (open_term) begin
				if (in_byte == CH_QUOTE) begin
					st = PS_QUO;
				end else begin
					st  = PS_UNQ;
					unq = 1'b1;
				end
			end

			if (unq || end_check) begin
				end_hit = 1'b1;
				if (in_byte == separator) begin
					st = PS_SOST;
					rc = RC_TERM;
				end else if (in_byte == CH_CR) begin
					st = PS_CR;
					rc = RC_ROW;
				end else if (in_byte == CH_LF) begin
					st = PS_SOST;
					rc = RC_ROW;
				end else begin
					end_hit = 1'b0;
				end
				if (!end_hit) begin
					if (end_check) begin
						rc = RC_ERR;
					end else begin
						append = 1'b1;
					end
				end
			end

			// drop the byte when the term is full
			if (append) begin
				if (({1'b0, cnt} + 9'd1) >= {1'b0, limit}) begin
					rc = RC_ERR;
				end else begin
					stored = 1'b1;
					idx    = cnt;
					cnt    = cnt + 8'd1;
				end
			end
		end
	end

	assign nxt.parse_state  = st;
	assign nxt.term_count   = cnt;
	assign res.status       = rc;
	assign res.byte_stored  = stored;
	assign res.stored_index = idx;
	assign res.term_length  = cnt;

endmodule

`default_nettype wire

>>> rtl/core/csv_byte_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_byte_tokenizer: CSV byte tokenizer top level
// Splits comma-separated text, one byte per beat, into terms and rows and
// reports per byte its status and where it lands in the current term.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// in        sink       in_valid/in_ready    in_byte
// out       source     out_valid/out_ready  status, byte_stored,
//                                           stored_index, term_length
// cfg       sink       cfg_wr_en            cfg_index, cfg_data
//
// One byte per cycle sustained while the output is not stalled; an accepted
// input beat reaches the output via the input register, then the result register.
// The parse state update sits between the two registers and sets the rate.
// Reset puts the parser at start of term with a zero count and loads the
// register defaults (separator 44, limit 64).
// A stalled output holds its beat; the input keeps accepting until both
// stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_byte_tokenizer
	import csvt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      status,
	output logic            byte_stored,
	output logic [7:0]      stored_index,
	output logic [7:0]      term_length,
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	logic [7:0] separator_q;
	logic [7:0] limit_q;
	parse_t     parse_q;
	parse_t     parse_nxt;
	result_t    res_nxt;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;
	logic       adv_s1;

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q <= SEPARATOR_RST;
			limit_q     <= LIMIT_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_SEPARATOR) begin
				separator_q <= cfg_data;
			end else if (cfg_index == REG_LIMIT) begin
				limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	csvt_step u_step (
		.in_byte   (byte_s1),
		.separator (separator_q),
		.limit     (limit_q),
		.cur       (parse_q),
		.nxt       (parse_nxt),
		.res       (res_nxt)
	);

	// advance the parse state only when the beat moves into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q.parse_state <= PS_SOST;
			parse_q.term_count  <= 8'd0;
			valid_s2            <= 1'b0;
		end else begin
			if (adv_s1) begin
				parse_q  <= parse_nxt;
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign status       = res_s2.status;
	assign byte_stored  = res_s2.byte_stored;
	assign stored_index = res_s2.stored_index;
	assign term_length  = res_s2.term_length;

endmodule

`default_nettype wire

>>> rtl/core/csvt_chk.sv
// ----------------------------------------------------------------------------
// csvt_chk: port checker of the CSV byte tokenizer
// Watches the top level ports for consistency of the result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_chk
	import csvt_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] status,
	input wire logic       byte_stored,
	input wire logic [7:0] stored_index,
	input wire logic [7:0] term_length
);

	// a stalled result beat holds its status, byte_stored and term_length
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(byte_stored) && $stable(term_length))
		else $error("stalled result beat changed");

	a_store_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_stored |-> status == RC_OK)
		else $error("stored byte with non-ok status");

	a_store_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_stored |-> term_length == stored_index + 8'd1)
		else $error("term length does not follow stored index");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> term_length != 8'd255)
		else $error("term length out of range");

endmodule

bind csv_byte_tokenizer csvt_chk u_csvt_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.byte_stored  (byte_stored),
	.stored_index (stored_index),
	.term_length  (term_length)
);

`default_nettype wire
